// File: src/bar_pkg.sv
package bar_pkg;

   // register indexes on the csr port
   localparam logic [1:0] CSR_PIN_INVERT    = 2'd0;
   localparam logic [1:0] CSR_REPEAT_PERIOD = 2'd1;
   localparam logic [1:0] CSR_HOLD_THRESH   = 2'd2;

   localparam int unsigned TIME_W   = 32;
   localparam int unsigned PERIOD_W = 16;

   // reset values of the registers
   localparam logic                PIN_INVERT_RST    = 1'b1;
   localparam logic [PERIOD_W-1:0] REPEAT_PERIOD_RST = 16'd200;
   localparam logic [PERIOD_W-1:0] HOLD_THRESH_RST   = 16'd1000;

   // divide by three: x * ceil(2^17 / 3) >> 17 is exact for every 16-bit x
   localparam int unsigned        DIV3_SHIFT = PERIOD_W + 1;
   localparam logic [PERIOD_W:0]  DIV3_MULT  = 17'd43691;

   typedef struct packed {
      logic                pin_invert;
      logic [PERIOD_W-1:0] repeat_period;
      logic [PERIOD_W-1:0] repeat_third;
      logic [PERIOD_W-1:0] hold_thresh;
   } cfg_type;

   typedef struct packed {
      logic [TIME_W-1:0] now_ms;
      logic              pin_level;
      logic              take_release;
   } item_type;

   typedef struct packed {
      logic              event_res;
      logic              is_pressed;
      logic [TIME_W-1:0] held_ms;
      logic [TIME_W-1:0] release_duration_ms;
   } result_type;

endpackage

// File: src/bar_cfg.sv
module bar_cfg
   import bar_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_we,
   input  logic [1:0]          csr_index,
   input  logic [PERIOD_W-1:0] csr_wdata,
   output cfg_type             cfg
);

   logic                pin_invert_ff;
   logic [PERIOD_W-1:0] period_ff;
   logic [PERIOD_W-1:0] third_ff;
   logic [PERIOD_W-1:0] thresh_ff;
   logic [PERIOD_W+PERIOD_W:0] third_prod;
   logic [PERIOD_W-1:0] third_in;

   // one third of the written period, worked out as the period is written
   assign third_prod = {{(PERIOD_W+1){1'b0}}, csr_wdata} * {{PERIOD_W{1'b0}}, DIV3_MULT};
   assign third_in   = third_prod[DIV3_SHIFT +: PERIOD_W];

   // register file
   always_ff @(posedge clock) begin
      if (reset) begin
         pin_invert_ff <= PIN_INVERT_RST;
         period_ff     <= REPEAT_PERIOD_RST;
         third_ff      <= PERIOD_W'(REPEAT_PERIOD_RST / 3);
         thresh_ff     <= HOLD_THRESH_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_PIN_INVERT: pin_invert_ff <= csr_wdata[0];
            CSR_REPEAT_PERIOD: begin
               period_ff <= csr_wdata;
               third_ff  <= third_in;
            end
            CSR_HOLD_THRESH: thresh_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign cfg.pin_invert    = pin_invert_ff;
   assign cfg.repeat_period = period_ff;
   assign cfg.repeat_third  = third_ff;
   assign cfg.hold_thresh   = thresh_ff;

endmodule

// File: src/bar_step.sv
module bar_step
   import bar_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       advance,
   input  item_type   item,
   input  cfg_type    cfg,
   output result_type result
);

   // held_ff doubles as the polarity-corrected level of the previous beat
   logic              held_ff,    held_in;
   logic [TIME_W-1:0] start_ff,   start_in;
   logic [TIME_W-1:0] report_ff,  report_in;
   logic [TIME_W-1:0] latched_ff, latched_in;

   logic              level;
   logic              press;
   logic              release_edge;
   logic [TIME_W-1:0] elapsed;
   logic [TIME_W-1:0] since_report;
   logic              fast;
   logic [PERIOD_W-1:0] rate;
   logic              fire;
   logic [TIME_W-1:0] duration;

   // edge detection, repeat test and result fields
   always_comb begin
      level        = item.pin_level ^ cfg.pin_invert;
      press        = level & ~held_ff;
      release_edge = ~level & held_ff;
      elapsed      = item.now_ms - start_ff;
      since_report = item.now_ms - report_ff;
      fast         = (cfg.hold_thresh != '0) &&
                     (elapsed > {{(TIME_W-PERIOD_W){1'b0}}, cfg.hold_thresh});
      rate         = fast ? cfg.repeat_third : cfg.repeat_period;
      fire         = held_ff && level && (cfg.repeat_period != '0) &&
                     (since_report > {{(TIME_W-PERIOD_W){1'b0}}, rate});
      duration     = release_edge ? elapsed : latched_ff;

      held_in    = level;
      start_in   = press ? item.now_ms : (release_edge ? '0 : start_ff);
      report_in  = (press || fire) ? item.now_ms : (release_edge ? '0 : report_ff);
      latched_in = item.take_release ? '0 : duration;

      result.event_res           = press | fire;
      result.is_pressed          = level;
      result.held_ms             = (level && !press) ? elapsed : '0;
      result.release_duration_ms = duration;
   end

   // press state
   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff    <= 1'b0;
         start_ff   <= '0;
         report_ff  <= '0;
         latched_ff <= '0;
      end else if (advance) begin
         held_ff    <= held_in;
         start_ff   <= start_in;
         report_ff  <= report_in;
         latched_ff <= latched_in;
      end
   end

endmodule

// File: src/button_autorepeat_press_timer_core.sv
// channel | ports      | direction | beat
// request | req_*      | in        | now_ms, pin_level, take_release
// response| rsp_*      | out       | event_res, is_pressed, held_ms, release_duration_ms
// csr     | csr_*      | in        | write enable, index, 16-bit data, no handshake
//
// one beat per cycle while rsp_ready stays high
// rsp valid once an accepted req has passed the input register and then
// the result register, with the press state updated alongside
// synchronous active-high reset clears valids, press state and csr to defaults
// a stalled rsp holds the result register; the input register takes one more beat
// and req_ready then stays low until the result is taken
module button_autorepeat_press_timer_core
   import bar_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [TIME_W-1:0]   req_now_ms,
   input  logic                req_pin_level,
   input  logic                req_take_release,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_event_res,
   output logic                rsp_is_pressed,
   output logic [TIME_W-1:0]   rsp_held_ms,
   output logic [TIME_W-1:0]   rsp_release_duration_ms,
   input  logic                csr_we,
   input  logic [1:0]          csr_index,
   input  logic [PERIOD_W-1:0] csr_wdata
);

   cfg_type    cfg;
   item_type   item_ff;
   logic       item_valid_ff;
   result_type result;
   result_type rsp_ff;
   logic       rsp_valid_ff;
   logic       advance;
   logic       out_free;

   // handshake control
   assign out_free  = ~rsp_valid_ff | rsp_ready;
   assign advance   = item_valid_ff & out_free;
   assign req_ready = ~item_valid_ff | advance;

   bar_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   bar_step u_step (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (item_ff),
      .cfg     (cfg),
      .result  (result)
   );

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (req_ready) begin
         item_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         item_ff.now_ms       <= req_now_ms;
         item_ff.pin_level    <= req_pin_level;
         item_ff.take_release <= req_take_release;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= item_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_event_res           = rsp_ff.event_res;
   assign rsp_is_pressed          = rsp_ff.is_pressed;
   assign rsp_held_ms             = rsp_ff.held_ms;
   assign rsp_release_duration_ms = rsp_ff.release_duration_ms;

endmodule

// File: sim/testbench.sv
module testbench
   import bar_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0]  CSR_UNMAPPED = 2'd3;
   localparam int unsigned SPEEDUP_DIV  = 3;
   localparam int          CYCLE_LIMIT  = 200000;
   localparam int          DRAIN_CYCLES = 4;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [TIME_W-1:0]   req_now_ms = '0;
   logic                req_pin_level = 1'b0;
   logic                req_take_release = 1'b0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic                rsp_event_res;
   logic                rsp_is_pressed;
   logic [TIME_W-1:0]   rsp_held_ms;
   logic [TIME_W-1:0]   rsp_release_duration_ms;
   logic                csr_we = 1'b0;
   logic [1:0]          csr_index = '0;
   logic [PERIOD_W-1:0] csr_wdata = '0;

   // shadow of the csr contents
   logic                cfg_pin_invert = PIN_INVERT_RST;
   logic [PERIOD_W-1:0] cfg_period     = REPEAT_PERIOD_RST;
   logic [PERIOD_W-1:0] cfg_thresh     = HOLD_THRESH_RST;

   // predicted button state
   logic                btn_level    = 1'b0;
   logic                btn_held     = 1'b0;
   logic [TIME_W-1:0]   btn_start    = '0;
   logic [TIME_W-1:0]   btn_last_rep = '0;
   logic [TIME_W-1:0]   btn_latched  = '0;

   item_type   samples_pending[$];
   result_type reports_due[$];
   item_type   cur_sample;
   result_type seen_report;
   result_type want_report;

   logic [TIME_W-1:0] t_ms = '0;
   int  phase_items = 0;
   int  fault_count = 0;
   int  cycle_count = 0;
   int  send_gap    = 0;
   int  sink_stall  = 0;
   bit  steady      = 1'b0;

   button_autorepeat_press_timer_core i_dut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // expected report for one sample, advancing the predicted state
   function automatic result_type next_button_report(item_type s);
      logic              lvl;
      logic              changed;
      logic [TIME_W-1:0] rate;
      result_type        r;
      lvl       = s.pin_level ^ cfg_pin_invert;
      changed   = (lvl != btn_level);
      btn_level = lvl;
      r.event_res = 1'b0;
      if (changed && lvl) begin
         btn_start    = s.now_ms;
         btn_held     = 1'b1;
         btn_last_rep = s.now_ms;
         r.event_res  = 1'b1;
      end else begin
         if (changed) begin
            btn_latched  = s.now_ms - btn_start;
            btn_start    = '0;
            btn_held     = 1'b0;
            btn_last_rep = '0;
         end
         if (cfg_period != 0 && btn_held) begin
            rate = TIME_W'(cfg_period);
            // long hold speeds repeat up
            if (cfg_thresh != 0 && (s.now_ms - btn_start) > TIME_W'(cfg_thresh))
               rate = rate / SPEEDUP_DIV;
            if ((s.now_ms - btn_last_rep) > rate) begin
               btn_last_rep = s.now_ms;
               r.event_res  = 1'b1;
            end
         end
      end
      r.is_pressed          = btn_held;
      r.held_ms             = btn_held ? s.now_ms - btn_start : '0;
      r.release_duration_ms = btn_latched;
      if (s.take_release)
         btn_latched = '0;
      return r;
   endfunction

   task automatic report_fault(input string msg);
      $display("ERROR cycle %0d: %s", cycle_count, msg);
      fault_count++;
   endtask

   task automatic check_field(input string name, input logic [TIME_W-1:0] got,
                              input logic [TIME_W-1:0] want);
      if (got !== want)
         report_fault($sformatf("%s got %0h want %0h", name, got, want));
   endtask

   // request driver
   always @(posedge clock) begin
      logic next_valid;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready)
            reports_due.push_back(next_button_report(cur_sample));
         if (!req_valid || req_ready) begin
            next_valid = 1'b0;
            if (send_gap > 0) begin
               send_gap--;
            end else if (samples_pending.size() != 0) begin
               cur_sample       = samples_pending.pop_front();
               req_now_ms       <= cur_sample.now_ms;
               req_pin_level    <= cur_sample.pin_level;
               req_take_release <= cur_sample.take_release;
               next_valid       = 1'b1;
               if (!steady && $urandom_range(0, 4) == 0)
                  send_gap = $urandom_range(1, 6);
            end
            req_valid <= next_valid;
         end
      end
   end

   // response monitor and sink stalls
   always @(posedge clock) begin
      cycle_count++;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (reports_due.size() == 0) begin
               report_fault("response beat with nothing expected");
            end else begin
               want_report = reports_due.pop_front();
               seen_report.event_res           = rsp_event_res;
               seen_report.is_pressed          = rsp_is_pressed;
               seen_report.held_ms             = rsp_held_ms;
               seen_report.release_duration_ms = rsp_release_duration_ms;
               check_field("event_res", TIME_W'(seen_report.event_res),
                           TIME_W'(want_report.event_res));
               check_field("is_pressed", TIME_W'(seen_report.is_pressed),
                           TIME_W'(want_report.is_pressed));
               check_field("held_ms", seen_report.held_ms, want_report.held_ms);
               check_field("release_duration_ms", seen_report.release_duration_ms,
                           want_report.release_duration_ms);
            end
         end
         if (sink_stall > 0) begin
            sink_stall--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if (!steady && $urandom_range(0, 4) == 0)
               sink_stall = $urandom_range(1, 6);
         end
      end
   end

   // watchdog
   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("Regression FAIL");
      $finish;
   end

   task automatic write_csr(input logic [1:0] idx, input logic [PERIOD_W-1:0] data);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_PIN_INVERT:    cfg_pin_invert = data[0];
         CSR_REPEAT_PERIOD: cfg_period     = data;
         CSR_HOLD_THRESH:   cfg_thresh     = data;
         default: ;
      endcase
   endtask

   task automatic wait_drained();
      do
         @(negedge clock);
      while (samples_pending.size() != 0 || req_valid || reports_due.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic push_raw(input item_type s);
      samples_pending.push_back(s);
      phase_items++;
   endtask

   // pressed is the polarity-corrected level
   task automatic push_sample(input logic [TIME_W-1:0] now, input logic pressed,
                              input logic take);
      item_type s;
      s.now_ms       = now;
      s.pin_level    = pressed ^ cfg_pin_invert;
      s.take_release = take;
      push_raw(s);
   endtask

   // time advance while held, aimed at the repeat and speed-up boundaries
   function automatic logic [TIME_W-1:0] hold_step();
      int unsigned base;
      int unsigned thr;
      base = (cfg_period == 0) ? 32'd100 : 32'(cfg_period);
      thr  = 32'(cfg_thresh);
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return base / 3;
         2:       return base / 3 + 1;
         3:       return base;
         4:       return base + 1;
         5:       return $urandom_range(0, 2 * base);
         6:       return TIME_W'(0) - $urandom_range(1, base);
         7:       return $urandom_range(0, base / 3 + 2);
         default: return $urandom_range(0, thr / 2 + 1);
      endcase
   endfunction

   function automatic logic rand_take();
      return ($urandom_range(0, 2) == 0);
   endfunction

   task automatic gen_traffic(input int n);
      item_type s;
      phase_items = 0;
      while (phase_items < n) begin
         case ($urandom_range(0, 9))
            // random garbage samples
            8: begin
               repeat ($urandom_range(1, 5)) begin
                  s.now_ms       = $urandom();
                  s.pin_level    = 1'($urandom_range(0, 1));
                  s.take_release = 1'($urandom_range(0, 1));
                  push_raw(s);
               end
            end
            // glitchy press
            9: begin
               t_ms += $urandom_range(1, 20);
               push_sample(t_ms, 1'b1, rand_take());
               t_ms += $urandom_range(0, 2);
               push_sample(t_ms, 1'b0, rand_take());
               if ($urandom_range(0, 1)) begin
                  push_sample(t_ms, 1'b1, rand_take());
                  push_sample(t_ms + 1, 1'b1, rand_take());
               end
            end
            // well-formed press, hold and release
            default: begin
               repeat ($urandom_range(0, 3)) begin
                  t_ms += $urandom_range(1, 50);
                  push_sample(t_ms, 1'b0, rand_take());
               end
               t_ms += $urandom_range(1, 50);
               push_sample(t_ms, 1'b1, rand_take());
               repeat ($urandom_range(1, 14)) begin
                  t_ms += hold_step();
                  push_sample(t_ms, 1'b1, rand_take());
               end
               t_ms += hold_step();
               push_sample(t_ms, 1'b0, rand_take());
               if ($urandom_range(0, 1))
                  push_sample(t_ms + 1, 1'b0, rand_take());
            end
         endcase
      end
   endtask

   task automatic run_phase(input logic inv, input logic [PERIOD_W-1:0] period,
                            input logic [PERIOD_W-1:0] thresh, input int n);
      logic [PERIOD_W-1:0] d;
      d    = PERIOD_W'($urandom());
      d[0] = inv;
      write_csr(CSR_PIN_INVERT, d);
      write_csr(CSR_REPEAT_PERIOD, period);
      write_csr(CSR_HOLD_THRESH, thresh);
      gen_traffic(n);
      wait_drained();
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: reset settings, pin low means pressed
      push_sample(32'h0000_0000, 1'b0, 1'b0);
      push_sample(32'd100, 1'b1, 1'b0);    // press edge
      push_sample(32'd300, 1'b1, 1'b0);    // exactly one period, strict so no repeat
      push_sample(32'd301, 1'b1, 1'b0);    // repeat
      push_sample(32'd301, 1'b1, 1'b0);    // no time passed
      push_sample(32'd1100, 1'b1, 1'b0);   // hold equals threshold, normal rate
      push_sample(32'd1101, 1'b1, 1'b0);   // fast rate from here
      push_sample(32'd1166, 1'b1, 1'b0);   // one third of period, not over
      push_sample(32'd1167, 1'b1, 1'b0);   // fast repeat
      push_sample(32'd1000, 1'b1, 1'b0);   // time going backwards
      push_sample(32'd1500, 1'b0, 1'b0);   // release edge latches duration
      push_sample(32'd1600, 1'b0, 1'b1);   // duration reported then taken
      push_sample(32'd1700, 1'b0, 1'b0);
      push_sample(32'hFFFF_FFF0, 1'b1, 1'b1);
      push_sample(32'h0000_0100, 1'b1, 1'b0); // held time across the wrap
      push_sample(32'hFFFF_FFFF, 1'b0, 1'b1);
      push_sample(32'hFFFF_FFFF, 1'b1, 1'b0);
      push_sample(32'hFFFF_FFFF, 1'b1, 1'b1);
      push_sample(32'h0000_0000, 1'b0, 1'b0); // release across the wrap
      push_sample(32'h5555_AAAA, 1'b0, 1'b1);
      push_sample(32'hAAAA_5555, 1'b0, 1'b0);
      wait_drained();

      // random phases over a spread of settings
      t_ms = $urandom();
      run_phase(1'b0, 16'd1, 16'd0, 200);
      t_ms = 32'hFFFF_0000;
      run_phase(1'b1, 16'd0, 16'hFFFF, 200);
      t_ms = $urandom();
      run_phase(1'b0, 16'hFFFF, 16'hFFFF, 200);
      run_phase(1'b1, 16'd2, 16'd1, 200);
      write_csr(CSR_UNMAPPED, PERIOD_W'($urandom()));
      run_phase(1'($urandom_range(0, 1)), PERIOD_W'($urandom_range(0, 2000)),
                PERIOD_W'($urandom_range(0, 4000)), 200);
      t_ms = 32'hFFFF_F000;
      run_phase(1'b1, REPEAT_PERIOD_RST, HOLD_THRESH_RST, 200);

      // closing phase without idling
      steady = 1'b1;
      run_phase(1'($urandom_range(0, 1)), PERIOD_W'($urandom_range(3, 300)),
                PERIOD_W'($urandom_range(0, 2000)), 200);

      if (reports_due.size() != 0)
         report_fault("expected responses left over");
      if (fault_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
